>>> hdl/smalu_pkg.sv
package smalu_pkg;

  // command codes carried in the low bits of the input item
  typedef enum logic [4:0] {
    CMD_PUSH  = 5'd0,
    CMD_POP   = 5'd1,
    CMD_TOP   = 5'd2,
    CMD_ADD   = 5'd3,
    CMD_SUB   = 5'd4,
    CMD_MUL   = 5'd5,
    CMD_DIV   = 5'd6,
    CMD_MOD   = 5'd7,
    CMD_INC   = 5'd8,
    CMD_DEC   = 5'd9,
    CMD_SWAP  = 5'd10,
    CMD_SIZE  = 5'd11,
    CMD_DUP   = 5'd12,
    CMD_CLEAR = 5'd13,
    CMD_EQ0   = 5'd14,
    CMD_LT0   = 5'd15,
    CMD_GT0   = 5'd16
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_OVER = 2'd1,
    ERR_FEW  = 2'd2,
    ERR_DIV0 = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DIV,
    ST_DFIN
  } state_t;

  localparam int WORD_W  = 32;
  localparam int CMD_W   = 5;
  localparam int CNT_W   = 8;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 48;
  localparam int DSTEP_W = 5;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic div_start;
    logic div_step;
    logic commit;
    err_t err;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t op;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic next_zero;
    logic div_last;
  } dp_stat_t;

endpackage

>>> hdl/smalu_ram.sv
module smalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/smalu_dp.sv
module smalu_dp
  import smalu_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         ctl,
  output dp_stat_t         stat,
  input  logic [IN_W-1:0]  in_data,
  output logic [OUT_W-1:0] out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  // latched item
  cmd_t              op;
  logic [WORD_W-1:0] pv;

  // stack state: top cached in a register, entries below it in the ram
  logic [CW-1:0]     cnt, cnt_next;
  logic [WORD_W-1:0] top, top_next;
  logic [WORD_W-1:0] nxt;

  // divider
  logic [WORD_W-1:0]  quo, rem, dvs;
  logic               neg_q, neg_r;
  logic [DSTEP_W-1:0] div_cnt;
  logic [WORD_W-1:0]  div_sh;
  logic [WORD_W:0]    div_trial;
  logic [WORD_W-1:0]  q_res, r_res;

  // ram write side
  logic              we;
  logic [CW-1:0]     waddr_w;
  logic [WORD_W-1:0] wdata;
  logic [CW-1:0]     raddr_w;
  logic [WORD_W-1:0] prod;
  logic              flag_v;

  // output register
  logic [WORD_W-1:0] o_top;
  logic              o_flag;
  err_t              o_err;
  logic [CW-1:0]     o_cnt;
  logic [CW+7:0]     o_cnt_ext;
  logic              ok;

  assign raddr_w = cnt - CNT_TWO;

  smalu_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_w[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_w[AW-1:0]),
    .rdata (nxt)
  );

  // status towards the controller
  always_comb begin
    stat.op        = op;
    stat.cnt_zero  = (cnt == '0);
    stat.cnt_lt2   = (cnt < CNT_TWO);
    stat.cnt_full  = (cnt == CNT_FULL);
    stat.next_zero = (nxt == '0);
    stat.div_last  = (div_cnt == {DSTEP_W{1'b1}});
  end

  // divider step and sign fix
  assign div_sh    = {rem[WORD_W-2:0], quo[WORD_W-1]};
  assign div_trial = {1'b0, div_sh} - {1'b0, dvs};
  assign q_res     = neg_q ? (WORD_W'(0) - quo) : quo;
  assign r_res     = neg_r ? (WORD_W'(0) - rem) : rem;
  assign prod      = WORD_W'(top * nxt);
  assign ok        = (ctl.err == ERR_OK);

  // commit of one command
  always_comb begin
    cnt_next = cnt;
    top_next = top;
    we       = 1'b0;
    waddr_w  = cnt - CNT_ONE;
    wdata    = top;
    flag_v   = 1'b0;
    case (op)
      CMD_PUSH: begin
        we       = (cnt != '0);
        top_next = pv;
        cnt_next = cnt + CNT_ONE;
      end
      CMD_POP: begin
        top_next = nxt;
        cnt_next = cnt - CNT_ONE;
      end
      CMD_ADD: begin
        top_next = top + nxt;
        cnt_next = cnt - CNT_ONE;
      end
      CMD_SUB: begin
        top_next = top - nxt;
        cnt_next = cnt - CNT_ONE;
      end
      CMD_MUL: begin
        top_next = prod;
        cnt_next = cnt - CNT_ONE;
      end
      CMD_DIV: begin
        top_next = q_res;
        cnt_next = cnt - CNT_ONE;
      end
      CMD_MOD: begin
        top_next = r_res;
        cnt_next = cnt - CNT_ONE;
      end
      CMD_INC: top_next = top + WORD_W'(1);
      CMD_DEC: top_next = top - WORD_W'(1);
      CMD_SWAP: begin
        we       = 1'b1;
        waddr_w  = cnt - CNT_TWO;
        top_next = nxt;
      end
      CMD_SIZE: begin
        we       = (cnt != '0);
        top_next = WORD_W'(cnt);
        cnt_next = cnt + CNT_ONE;
      end
      CMD_DUP: begin
        we       = 1'b1;
        cnt_next = cnt + CNT_ONE;
      end
      CMD_CLEAR: begin
        flag_v   = (cnt == '0);
        cnt_next = '0;
      end
      CMD_EQ0: flag_v = (top == '0);
      CMD_LT0: flag_v = top[WORD_W-1];
      CMD_GT0: flag_v = (top != '0) && !top[WORD_W-1];
      default: ;
    endcase
    if (!(ctl.commit && ok)) begin
      we       = 1'b0;
      cnt_next = cnt;
      top_next = top;
    end
    if (!ok) begin
      flag_v = 1'b0;
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // item latch, top, divider and result registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op <= cmd_t'(in_data[CMD_W-1:0]);
      pv <= in_data[CMD_W+WORD_W-1:CMD_W];
    end
    top <= top_next;
    if (ctl.div_start) begin
      quo     <= top[WORD_W-1] ? (WORD_W'(0) - top) : top;
      dvs     <= nxt[WORD_W-1] ? (WORD_W'(0) - nxt) : nxt;
      rem     <= '0;
      neg_q   <= top[WORD_W-1] ^ nxt[WORD_W-1];
      neg_r   <= top[WORD_W-1];
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt + DSTEP_W'(1);
      if (!div_trial[WORD_W]) begin
        rem <= div_trial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= div_sh;
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
    if (ctl.commit) begin
      o_top  <= (cnt_next != '0) ? top_next : '0;
      o_flag <= flag_v;
      o_err  <= ctl.err;
      o_cnt  <= cnt_next;
    end
  end

  // pack the result item
  assign o_cnt_ext = {8'd0, o_cnt};
  assign out_data  = {3'd0, (o_cnt == CNT_FULL), (o_cnt == '0), o_cnt_ext[CNT_W-1:0],
                      o_err, o_flag, o_top};

endmodule

>>> hdl/smalu_ctrl.sv
module smalu_ctrl
  import smalu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state, state_next;
  logic   out_valid_next;
  err_t   err_v;

  // error decision from the latched command and the stack status
  always_comb begin
    err_v = ERR_OK;
    case (stat.op)
      CMD_PUSH, CMD_SIZE: if (stat.cnt_full) err_v = ERR_OVER;
      CMD_POP, CMD_TOP, CMD_INC, CMD_DEC, CMD_EQ0, CMD_LT0, CMD_GT0:
        if (stat.cnt_zero) err_v = ERR_FEW;
      CMD_DUP: begin
        if (stat.cnt_zero) err_v = ERR_FEW;
        else if (stat.cnt_full) err_v = ERR_OVER;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_SWAP: if (stat.cnt_lt2) err_v = ERR_FEW;
      CMD_DIV, CMD_MOD: begin
        if (stat.cnt_lt2) err_v = ERR_FEW;
        else if (stat.next_zero) err_v = ERR_DIV0;
      end
      default: err_v = ERR_OK;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    ctl.latch     = 1'b0;
    ctl.div_start = 1'b0;
    ctl.div_step  = 1'b0;
    ctl.commit    = 1'b0;
    ctl.err       = err_v;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = !out_valid || out_ready;
        ctl.latch = in_valid && in_ready;
        if (ctl.latch) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_EXEC;
      ST_EXEC: begin
        if ((stat.op == CMD_DIV || stat.op == CMD_MOD) && err_v == ERR_OK) begin
          ctl.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) state_next = ST_DFIN;
      end
      ST_DFIN: begin
        ctl.commit = 1'b1;
        ctl.err    = ERR_OK;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = ctl.commit || (out_valid && !out_ready);
  end

endmodule

>>> hdl/stack_machine_alu_top.sv
// evaluation stack alu of signed 32-bit words
// input channel s_axis: one item is a command and a word to push; it is taken
// when s_axis_tvalid and s_axis_tready are both high
// output channel m_axis: exactly one result item per input item, in order
// every command passes the fetch and exec states before its result is
// registered; divide and modulo without an error also pass the div and dfin
// states, as the shared restoring divider resolves one quotient bit per cycle over 32 steps
// one item in flight at a time: no item is taken before the last one's
// result is committed; the top entry sits in a register and the ram read port
// addresses the entry below it
// a result waits in the output register while m_axis_tready is low; the next
// item is taken in the same cycle the waiting result leaves
// reset empties the stack (count to zero) and drops any pending result; the
// ram needs no clearing pass as only written entries are ever read
module stack_machine_alu_top
  import smalu_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[4:0], push_value[36:5], zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // top_value[31:0], flag[32], error[34:33], depth_count[42:35],
  // empty_res[43], full_res[44], zero fill
  output logic [OUT_W-1:0] m_axis_tdata
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  smalu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  smalu_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

  // one item at a time: no acceptance right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  // a result is never written over a waiting one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten");

  // empty and full marks never both set
  a_marks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[43] && m_axis_tdata[44]))
    else $error("empty and full both set");

  // divider only runs for divide or modulo
  a_div_op: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |-> (stat.op == CMD_DIV || stat.op == CMD_MOD))
    else $error("divider started for another command");

endmodule
